### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/ftpu_pkg.sv
package ftpu_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PREFIX    = 3'd1,
        ST_USERPASS  = 3'd2,
        ST_CRED_LONG = 3'd3,
        ST_NO_PATH   = 3'd4,
        ST_HOST_LONG = 3'd5,
        ST_URL_LONG  = 3'd6
    } ftpu_status_t;

    localparam int SCHEME_LEN = 6;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        ftpu_status_t status;
        logic         anonymous;
        logic [7:0]   user_length;
        logic [9:0]   pass_start;
        logic [7:0]   pass_length;
        logic [9:0]   host_start;
        logic [7:0]   host_length;
        logic [9:0]   path_start;
        logic [7:0]   path_len;
    } ftpu_result_t;

    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h3A;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/ftpu_scan.sv
module ftpu_scan #(
    parameter int URL_MAX = 1024,
    localparam int CW = $clog2(URL_MAX + 2),
    localparam int PW = $clog2(URL_MAX)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    url_byte,
    input  logic          last,
    output logic [CW-1:0] snap_count,
    output logic          snap_prefix_ok,
    output logic          snap_at_seen,
    output logic [PW-1:0] snap_at_pos,
    output logic          snap_colon_seen,
    output logic [PW-1:0] snap_colon_pos,
    output logic          snap_slash_seen,
    output logic [PW-1:0] snap_slash_pos,
    output logic          snap_saa_seen,
    output logic [PW-1:0] snap_saa_pos
);
    import ftpu_pkg::*;

    logic [CW-1:0] count_reg, count_next;
    logic          prefix_ok_reg, prefix_ok_next;
    logic          at_seen_reg, at_seen_next;
    logic [PW-1:0] at_pos_reg, at_pos_next;
    logic          colon_seen_reg, colon_seen_next;
    logic [PW-1:0] colon_pos_reg, colon_pos_next;
    logic          slash_seen_reg, slash_seen_next;
    logic [PW-1:0] slash_pos_reg, slash_pos_next;
    logic          saa_seen_reg, saa_seen_next;
    logic [PW-1:0] saa_pos_reg, saa_pos_next;
    logic [PW-1:0] pos;

    assign pos = count_reg[PW-1:0];

    always_comb
    begin
        count_next      = count_reg;
        prefix_ok_next  = prefix_ok_reg;
        at_seen_next    = at_seen_reg;
        at_pos_next     = at_pos_reg;
        colon_seen_next = colon_seen_reg;
        colon_pos_next  = colon_pos_reg;
        slash_seen_next = slash_seen_reg;
        slash_pos_next  = slash_pos_reg;
        saa_seen_next   = saa_seen_reg;
        saa_pos_next    = saa_pos_reg;
        if (count_reg < CW'(URL_MAX))
        begin
            if (count_reg < CW'(SCHEME_LEN))
            begin
                if (url_byte != scheme_char(count_reg[2:0]))
                    prefix_ok_next = 1'b0;
            end
            else
            begin
                if (url_byte == CH_SLASH && at_seen_reg && !saa_seen_reg)
                begin
                    saa_seen_next = 1'b1;
                    saa_pos_next  = pos;
                end
                if (url_byte == CH_AT && !at_seen_reg)
                begin
                    at_seen_next = 1'b1;
                    at_pos_next  = pos;
                end
                if (url_byte == CH_COLON && !colon_seen_reg)
                begin
                    colon_seen_next = 1'b1;
                    colon_pos_next  = pos;
                end
                if (url_byte == CH_SLASH && !slash_seen_reg)
                begin
                    slash_seen_next = 1'b1;
                    slash_pos_next  = pos;
                end
            end
        end
        if (count_reg <= CW'(URL_MAX))
            count_next = count_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prefix_ok_reg  <= 1'b1;
            at_seen_reg    <= 1'b0;
            at_pos_reg     <= '0;
            colon_seen_reg <= 1'b0;
            colon_pos_reg  <= '0;
            slash_seen_reg <= 1'b0;
            slash_pos_reg  <= '0;
            saa_seen_reg   <= 1'b0;
            saa_pos_reg    <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg      <= '0;
                prefix_ok_reg  <= 1'b1;
                at_seen_reg    <= 1'b0;
                at_pos_reg     <= '0;
                colon_seen_reg <= 1'b0;
                colon_pos_reg  <= '0;
                slash_seen_reg <= 1'b0;
                slash_pos_reg  <= '0;
                saa_seen_reg   <= 1'b0;
                saa_pos_reg    <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                prefix_ok_reg  <= prefix_ok_next;
                at_seen_reg    <= at_seen_next;
                at_pos_reg     <= at_pos_next;
                colon_seen_reg <= colon_seen_next;
                colon_pos_reg  <= colon_pos_next;
                slash_seen_reg <= slash_seen_next;
                slash_pos_reg  <= slash_pos_next;
                saa_seen_reg   <= saa_seen_next;
                saa_pos_reg    <= saa_pos_next;
            end
        end
    end

    assign snap_count      = count_next;
    assign snap_prefix_ok  = prefix_ok_next;
    assign snap_at_seen    = at_seen_next;
    assign snap_at_pos     = at_pos_next;
    assign snap_colon_seen = colon_seen_next;
    assign snap_colon_pos  = colon_pos_next;
    assign snap_slash_seen = slash_seen_next;
    assign snap_slash_pos  = slash_pos_next;
    assign snap_saa_seen   = saa_seen_next;
    assign snap_saa_pos    = saa_pos_next;

endmodule

### rtl/ftpu_eval.sv
module ftpu_eval #(
    parameter int FIELD_MAX = 256,
    parameter int URL_MAX = 1024,
    localparam int CW = $clog2(URL_MAX + 2),
    localparam int PW = $clog2(URL_MAX),
    localparam int FW = $clog2(FIELD_MAX) + 1,
    localparam int LA = (CW > FW) ? CW : FW,
    localparam int LW = (LA > 10) ? LA : 10
) (
    input  logic                   [CW-1:0] count,
    input  logic                            prefix_ok,
    input  logic                            at_seen,
    input  logic                   [PW-1:0] at_pos,
    input  logic                            colon_seen,
    input  logic                   [PW-1:0] colon_pos,
    input  logic                            slash_seen,
    input  logic                   [PW-1:0] slash_pos,
    input  logic                            saa_seen,
    input  logic                   [PW-1:0] saa_pos,
    output ftpu_pkg::ftpu_result_t          result
);
    import ftpu_pkg::*;

    function automatic logic [7:0] sat8(input logic [LW-1:0] v);
        return (v > LW'(255)) ? 8'hFF : v[7:0];
    endfunction

    always_comb
    begin
        ftpu_status_t   status;
        logic [LW-1:0]  len;
        logic [LW-1:0]  atp;
        logic [LW-1:0]  colp;
        logic [LW-1:0]  slash;
        logic [LW-1:0]  user_length;
        logic [LW-1:0]  pass_length;
        logic [LW-1:0]  pass_start;
        logic [LW-1:0]  host_start;
        logic [LW-1:0]  host_length;
        logic [LW-1:0]  path_len;
        logic           have_slash;

        result      = '0;
        status      = ST_OK;
        len         = LW'(count);
        atp         = LW'(at_pos);
        colp        = LW'(colon_pos);
        user_length = '0;
        pass_length = '0;
        pass_start  = '0;
        have_slash  = at_seen ? saa_seen : slash_seen;
        slash       = at_seen ? LW'(saa_pos) : LW'(slash_pos);
        host_start  = at_seen ? atp + LW'(1) : LW'(SCHEME_LEN);
        host_length = slash - host_start;
        path_len    = len - slash;

        if (len > LW'(URL_MAX))
            status = ST_URL_LONG;
        else if (!prefix_ok || len < LW'(SCHEME_LEN))
            status = ST_PREFIX;
        else
        begin
            if (at_seen)
            begin
                if (!colon_seen || colp > atp)
                    status = ST_USERPASS;
                else
                begin
                    user_length = colp - LW'(SCHEME_LEN);
                    pass_length = atp - colp - LW'(1);
                    pass_start  = colp + LW'(1);
                    if (user_length >= LW'(FIELD_MAX) || pass_length >= LW'(FIELD_MAX))
                        status = ST_CRED_LONG;
                end
            end
            if (status == ST_OK)
            begin
                if (!have_slash)
                    status = ST_NO_PATH;
                else if (host_length >= LW'(FIELD_MAX))
                    status = ST_HOST_LONG;
                else
                begin
                    if (path_len > LW'(FIELD_MAX - 1))
                        path_len = LW'(FIELD_MAX - 1);
                    result.anonymous   = !at_seen;
                    result.user_length = sat8(user_length);
                    result.pass_start  = pass_start[9:0];
                    result.pass_length = sat8(pass_length);
                    result.host_start  = host_start[9:0];
                    result.host_length = sat8(host_length);
                    result.path_start  = slash[9:0];
                    result.path_len    = sat8(path_len);
                end
            end
        end
        result.status = status;
    end

endmodule

### rtl/ftp_url_field_splitter_unit.sv
// Splits an ftp URL, streamed one byte per transfer with tlast on the final
// byte, into user, password, host and path fields. A byte is taken every
// clock unless the master side holds the flow; a URL's result goes through
// the snapshot register and then the result register to the master side,
// and a new URL may start on the very next cycle. The byte scanner and the
// two registers form a pipeline held only by master-side back-pressure.
// Status codes: 0 ok, 1 bad prefix, 2 bad user:pass, 3 credential too
// long, 4 no path, 5 host too long, 6 URL longer than URL_MAX. On any
// nonzero status all other result fields are zero.
`include "assert_macros.svh"

module ftp_url_field_splitter_unit #(
    parameter int FIELD_MAX = 256,
    parameter int URL_MAX = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] url_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] user length, [17:8] pass_start, [25:18] password length,
    // [35:26] host_start, [43:36] host length, [53:44] path_start,
    // [61:54] path_len, [63:62] zero
    output logic [63:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser    // [2:0] status, [3] anonymous
);
    import ftpu_pkg::*;

    localparam int CW = $clog2(URL_MAX + 2);
    localparam int PW = $clog2(URL_MAX);

    logic          s_accept;
    logic          adv_out;
    logic          adv_snap;

    logic [CW-1:0] scan_count;
    logic          scan_prefix_ok;
    logic          scan_at_seen;
    logic [PW-1:0] scan_at_pos;
    logic          scan_colon_seen;
    logic [PW-1:0] scan_colon_pos;
    logic          scan_slash_seen;
    logic [PW-1:0] scan_slash_pos;
    logic          scan_saa_seen;
    logic [PW-1:0] scan_saa_pos;

    logic          snap_valid_reg;
    logic [CW-1:0] snap_count_reg;
    logic          snap_prefix_ok_reg;
    logic          snap_at_seen_reg;
    logic [PW-1:0] snap_at_pos_reg;
    logic          snap_colon_seen_reg;
    logic [PW-1:0] snap_colon_pos_reg;
    logic          snap_slash_seen_reg;
    logic [PW-1:0] snap_slash_pos_reg;
    logic          snap_saa_seen_reg;
    logic [PW-1:0] snap_saa_pos_reg;

    ftpu_result_t  eval_result;
    ftpu_result_t  out_reg;
    logic          out_valid_reg;

    assign adv_out       = !out_valid_reg || m_axis_tready;
    assign adv_snap      = !snap_valid_reg || adv_out;
    assign s_axis_tready = adv_snap;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    ftpu_scan #(
        .URL_MAX (URL_MAX)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (s_accept),
        .url_byte        (s_axis_tdata),
        .last            (s_axis_tlast),
        .snap_count      (scan_count),
        .snap_prefix_ok  (scan_prefix_ok),
        .snap_at_seen    (scan_at_seen),
        .snap_at_pos     (scan_at_pos),
        .snap_colon_seen (scan_colon_seen),
        .snap_colon_pos  (scan_colon_pos),
        .snap_slash_seen (scan_slash_seen),
        .snap_slash_pos  (scan_slash_pos),
        .snap_saa_seen   (scan_saa_seen),
        .snap_saa_pos    (scan_saa_pos)
    );

    // capture the final scan state on the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (s_accept && s_axis_tlast)
            snap_valid_reg <= 1'b1;
        else if (adv_out)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_axis_tlast)
        begin
            snap_count_reg      <= scan_count;
            snap_prefix_ok_reg  <= scan_prefix_ok;
            snap_at_seen_reg    <= scan_at_seen;
            snap_at_pos_reg     <= scan_at_pos;
            snap_colon_seen_reg <= scan_colon_seen;
            snap_colon_pos_reg  <= scan_colon_pos;
            snap_slash_seen_reg <= scan_slash_seen;
            snap_slash_pos_reg  <= scan_slash_pos;
            snap_saa_seen_reg   <= scan_saa_seen;
            snap_saa_pos_reg    <= scan_saa_pos;
        end
    end

    ftpu_eval #(
        .FIELD_MAX (FIELD_MAX),
        .URL_MAX   (URL_MAX)
    ) u_eval (
        .count      (snap_count_reg),
        .prefix_ok  (snap_prefix_ok_reg),
        .at_seen    (snap_at_seen_reg),
        .at_pos     (snap_at_pos_reg),
        .colon_seen (snap_colon_seen_reg),
        .colon_pos  (snap_colon_pos_reg),
        .slash_seen (snap_slash_seen_reg),
        .slash_pos  (snap_slash_pos_reg),
        .saa_seen   (snap_saa_seen_reg),
        .saa_pos    (snap_saa_pos_reg),
        .result     (eval_result)
    );

    // advance the result register whenever the master side frees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_out)
            out_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && snap_valid_reg)
            out_reg <= eval_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.path_len, out_reg.path_start, out_reg.host_length,
                            out_reg.host_start, out_reg.pass_length, out_reg.pass_start,
                            out_reg.user_length};
    assign m_axis_tuser  = {out_reg.anonymous, out_reg.status};

    `ASSERT_SAME(a_err_zero, clk, rst_n, out_valid_reg && out_reg.status != ST_OK, m_axis_tdata == 64'd0 && !out_reg.anonymous)
    `ASSERT_SAME(a_anon_nocred, clk, rst_n, out_valid_reg && out_reg.anonymous, out_reg.user_length == 8'd0 && out_reg.pass_length == 8'd0 && out_reg.pass_start == 10'd0)
    `ASSERT_NEXT(a_last_snap, clk, rst_n, s_accept && s_axis_tlast, snap_valid_reg)
    `ASSERT_NEXT(a_snap_out, clk, rst_n, snap_valid_reg && adv_out, out_valid_reg)

endmodule
